/* src/cmsw_pkg.sv */
package cmsw_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_COLS = 320;
    localparam int DEF_SCREEN_ROWS = 200;

    // item modes
    localparam logic [1:0] MODE_SEED = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_COMP = 2'd2;

    // seed offsets live in -15..0
    localparam int SEED_W = 5;

    typedef logic [SEED_W-1:0] seed_t;

    // byte modulo 3: sum of base-4 digits keeps the residue, then a small table
    function automatic logic [1:0] mod3(input logic [7:0] x);
        logic [3:0] s;
        logic [1:0] r;
        s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
        case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
            default:                       r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/column_melt_screen_wipe_unit.sv */
// seed and unused-mode items: the result goes out through the done state once the output slot is free
// compose items: one offset read per pixel
// tick items: one column per tick per cycle
// one item at a time; the single read port of the offset memory sets the pace
// aresetn (synchronous, active low) clears control and the last seed; the
// offset memory holds garbage until each column is seeded
module column_melt_screen_wipe_unit #(
    parameter int SCREEN_COLS = cmsw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = cmsw_pkg::DEF_SCREEN_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [8:0] s_pixel_column,
    input  logic [7:0] s_rand_value,
    input  logic [3:0] s_tick_count,
    input  logic [5:0] s_byte_column,
    input  logic [7:0] s_row,
    input  logic [7:0] s_start_byte,
    input  logic [7:0] s_end_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pixel_byte,
    output logic       m_wipe_done
);

    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int OFS_W = $clog2(SCREEN_ROWS + 1) + 1;
    localparam int MAG_W = OFS_W - 1;
    localparam int IDX_W = (COL_W > 9) ? COL_W : 9;
    localparam int CMP_W = IDX_W + 1;
    localparam int U_W   = (MAG_W > 8) ? MAG_W : 8;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);
    localparam logic [CMP_W-1:0] COLS_C   = CMP_W'(SCREEN_COLS);
    localparam logic [MAG_W-1:0] ROWS_M   = MAG_W'(SCREEN_ROWS);
    localparam logic [OFS_W-1:0] ROWS_O   = OFS_W'(SCREEN_ROWS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_COMP = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // control registers
    logic [1:0]       state_reg, state_next;
    logic             issue_reg, issue_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic             m_valid_reg, m_valid_next;
    cmsw_pkg::seed_t  prev_seed_reg, prev_seed_next;

    // payload registers
    logic [COL_W-1:0] idx_reg, idx_next;
    logic [3:0]       ticks_left_reg, ticks_left_next;
    logic             moved_reg, moved_next;
    logic [COL_W-1:0] pipe_addr_reg, pipe_addr_next;
    logic             pipe_inr_reg, pipe_inr_next;
    logic [2:0]       pipe_bit_reg, pipe_bit_next;
    logic [2:0]       bit_reg, bit_next;
    logic [5:0]       bcol_reg, bcol_next;
    logic [7:0]       row_reg, row_next;
    logic [7:0]       sb_reg, sb_next;
    logic [7:0]       eb_reg, eb_next;
    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       res_pixel_reg, res_pixel_next;
    logic             res_done_reg, res_done_next;
    logic [7:0]       m_pixel_reg, m_pixel_next;
    logic             m_done_reg, m_done_next;

    // offset memory
    logic [OFS_W-1:0] offset_mem [SCREEN_COLS];
    logic [OFS_W-1:0] rd_data_reg;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [OFS_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            offset_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= offset_mem[rd_addr];
    end

    // seed value from the random byte
    logic [IDX_W-1:0] pcol_ext;
    logic             pcol_in_range;
    logic [1:0]       seed_m;
    logic [5:0]       seed_sum;
    cmsw_pkg::seed_t  seed_v;

    always_comb begin
        pcol_ext      = IDX_W'(s_pixel_column);
        pcol_in_range = CMP_W'(pcol_ext) < COLS_C;
        seed_m        = cmsw_pkg::mod3(s_rand_value);
        seed_sum      = {prev_seed_reg[4], prev_seed_reg} + 6'(seed_m) - 6'd1;
        if (s_pixel_column == 9'd0) begin
            seed_v = 5'd0 - {1'b0, s_rand_value[3:0]};
        end else if (!seed_sum[5] && seed_sum != 6'd0) begin
            // capped at zero
            seed_v = 5'd0;
        end else if (seed_sum == 6'b110000) begin
            // -16 folds to -15
            seed_v = 5'b10001;
        end else begin
            seed_v = seed_sum[4:0];
        end
    end

    // melt step of one column, on the memory read data
    logic [MAG_W-1:0] y_mag;
    logic [MAG_W-1:0] grow;
    logic [OFS_W-1:0] grow_sum;
    logic [OFS_W-1:0] tick_new;
    logic             tick_moved;

    always_comb begin
        y_mag    = rd_data_reg[MAG_W-1:0];
        grow     = (y_mag < MAG_W'(16)) ? (y_mag + MAG_W'(1)) : MAG_W'(8);
        grow_sum = {1'b0, y_mag} + {1'b0, grow};
        if (grow_sum >= ROWS_O) begin
            grow_sum = ROWS_O;
        end
        if (rd_data_reg[OFS_W-1]) begin
            tick_new   = rd_data_reg + OFS_W'(1);
            tick_moved = 1'b1;
        end else if (y_mag < ROWS_M) begin
            tick_new   = grow_sum;
            tick_moved = 1'b1;
        end else begin
            tick_new   = rd_data_reg;
            tick_moved = 1'b0;
        end
    end

    // compose: column address and pixel select
    logic [IDX_W-1:0] comp_col;
    logic             comp_in_range;
    logic             take_end;
    logic             comp_bit;

    always_comb begin
        comp_col      = IDX_W'({bcol_reg, bit_reg});
        comp_in_range = CMP_W'(comp_col) < COLS_C;
        take_end      = pipe_inr_reg && !rd_data_reg[OFS_W-1]
                        && (U_W'(row_reg) < U_W'(y_mag));
        comp_bit      = take_end ? eb_reg[3'd7 - pipe_bit_reg]
                                 : sb_reg[3'd7 - pipe_bit_reg];
    end

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        pipe_vld_next   = 1'b0;
        m_valid_next    = m_valid_reg;
        prev_seed_next  = prev_seed_reg;
        idx_next        = idx_reg;
        ticks_left_next = ticks_left_reg;
        moved_next      = moved_reg;
        pipe_addr_next  = pipe_addr_reg;
        pipe_inr_next   = pipe_inr_reg;
        pipe_bit_next   = pipe_bit_reg;
        bit_next        = bit_reg;
        bcol_next       = bcol_reg;
        row_next        = row_reg;
        sb_next         = sb_reg;
        eb_next         = eb_reg;
        acc_next        = acc_reg;
        res_pixel_next  = res_pixel_reg;
        res_done_next   = res_done_reg;
        m_pixel_next    = m_pixel_reg;
        m_done_next     = m_done_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = pipe_addr_reg;
        wr_data         = tick_new;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_pixel_next = 8'd0;
                    res_done_next  = 1'b0;
                    case (s_mode)
                        cmsw_pkg::MODE_SEED: begin
                            if (pcol_in_range) begin
                                wr_en          = 1'b1;
                                wr_addr        = pcol_ext[COL_W-1:0];
                                wr_data        = {{(OFS_W - cmsw_pkg::SEED_W){seed_v[4]}},
                                                  seed_v};
                                prev_seed_next = seed_v;
                            end
                            state_next = ST_DONE;
                        end
                        cmsw_pkg::MODE_TICK: begin
                            if (s_tick_count == 4'd0) begin
                                res_done_next = 1'b1;
                                state_next    = ST_DONE;
                            end else begin
                                idx_next        = '0;
                                ticks_left_next = s_tick_count;
                                moved_next      = 1'b0;
                                issue_next      = 1'b1;
                                state_next      = ST_TICK;
                            end
                        end
                        cmsw_pkg::MODE_COMP: begin
                            bcol_next  = s_byte_column;
                            row_next   = s_row;
                            sb_next    = s_start_byte;
                            eb_next    = s_end_byte;
                            bit_next   = 3'd0;
                            acc_next   = 8'd0;
                            issue_next = 1'b1;
                            state_next = ST_COMP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // read one column, write it back updated in the cycle after
                if (issue_reg) begin
                    pipe_vld_next  = 1'b1;
                    pipe_addr_next = idx_reg;
                    if (idx_reg == COL_LAST) begin
                        idx_next        = '0;
                        ticks_left_next = ticks_left_reg - 4'd1;
                        if (ticks_left_reg == 4'd1) begin
                            issue_next = 1'b0;
                        end
                    end else begin
                        idx_next = idx_reg + COL_W'(1);
                    end
                end
                if (pipe_vld_reg) begin
                    wr_en      = 1'b1;
                    moved_next = moved_reg | tick_moved;
                end
                if (!issue_reg && !pipe_vld_reg) begin
                    res_done_next = !moved_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_COMP: begin
                // one pixel column per cycle, leftmost first
                rd_addr = comp_col[COL_W-1:0];
                if (issue_reg) begin
                    pipe_vld_next = 1'b1;
                    pipe_inr_next = comp_in_range;
                    pipe_bit_next = bit_reg;
                    bit_next      = bit_reg + 3'd1;
                    if (bit_reg == 3'd7) begin
                        issue_next = 1'b0;
                    end
                end
                if (pipe_vld_reg) begin
                    acc_next = {acc_reg[6:0], comp_bit};
                end
                if (!issue_reg && !pipe_vld_reg) begin
                    res_pixel_next = acc_reg;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pixel_next = res_pixel_reg;
                    m_done_next  = res_done_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            pipe_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            prev_seed_reg <= '0;
        end else begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pipe_vld_reg  <= pipe_vld_next;
            m_valid_reg   <= m_valid_next;
            prev_seed_reg <= prev_seed_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        ticks_left_reg <= ticks_left_next;
        moved_reg      <= moved_next;
        pipe_addr_reg  <= pipe_addr_next;
        pipe_inr_reg   <= pipe_inr_next;
        pipe_bit_reg   <= pipe_bit_next;
        bit_reg        <= bit_next;
        bcol_reg       <= bcol_next;
        row_reg        <= row_next;
        sb_reg         <= sb_next;
        eb_reg         <= eb_next;
        acc_reg        <= acc_next;
        res_pixel_reg  <= res_pixel_next;
        res_done_reg   <= res_done_next;
        m_pixel_reg    <= m_pixel_next;
        m_done_reg     <= m_done_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_byte = m_pixel_reg;
    assign m_wipe_done  = m_done_reg;

    // busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block accepted a beat and stayed ready");

    // a finished result reaches the output when the slot is free
    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && (!m_valid_reg || m_ready) |=> m_valid && s_ready)
        else $error("finished result not delivered");

    // the read pipe runs only inside a walk
    a_pipe_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> (state_reg == ST_TICK) || (state_reg == ST_COMP))
        else $error("read pipe active outside a walk");

    // a tick walk never issues with no ticks left
    a_ticks_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) && issue_reg |-> ticks_left_reg != 4'd0)
        else $error("tick walk issued with no ticks left");

    // a result never carries both a nonzero pixel byte and a done flag
    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_wipe_done && (m_pixel_byte != 8'd0)))
        else $error("result has both a pixel byte and a done flag");

endmodule

/* tb/tb_column_melt_screen_wipe_unit.sv */
module tb_column_melt_screen_wipe_unit;

    localparam int SCREEN_COLS = cmsw_pkg::DEF_SCREEN_COLS;
    localparam int SCREEN_ROWS = cmsw_pkg::DEF_SCREEN_ROWS;
    localparam logic [1:0] MODE_SEED = cmsw_pkg::MODE_SEED;
    localparam logic [1:0] MODE_TICK = cmsw_pkg::MODE_TICK;
    localparam logic [1:0] MODE_COMP = cmsw_pkg::MODE_COMP;
    // mode code the block leaves unused
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int DIR_N = 20;
    localparam int WIPE_COUNT = 4;
    localparam int MELT_ITEMS_MAX = 800;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] pixel_column;
        logic [7:0] rand_value;
        logic [3:0] tick_count;
        logic [5:0] byte_column;
        logic [7:0] row;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } melt_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       wipe_done;
    } melt_result_t;

    // one directed row: the item, and its result where it is obvious
    typedef struct packed {
        melt_item_t   item;
        logic         typed;
        melt_result_t want;
    } dir_row_t;

    typedef logic signed [8:0] offset_t;
    typedef logic signed [4:0] seed_sgn_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = '0;
    logic [8:0] s_pixel_column = '0;
    logic [7:0] s_rand_value = '0;
    logic [3:0] s_tick_count = '0;
    logic [5:0] s_byte_column = '0;
    logic [7:0] s_row = '0;
    logic [7:0] s_start_byte = '0;
    logic [7:0] s_end_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_pixel_byte;
    logic       m_wipe_done;

    // predicted screen state
    offset_t   col_offset [SCREEN_COLS];
    seed_sgn_t last_seed = '0;
    logic      melt_settled = 1'b0;

    melt_result_t melt_results_due [$];
    dir_row_t     dir_rows [DIR_N];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    column_melt_screen_wipe_unit #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_pixel_column(s_pixel_column),
        .s_rand_value  (s_rand_value),
        .s_tick_count  (s_tick_count),
        .s_byte_column (s_byte_column),
        .s_row         (s_row),
        .s_start_byte  (s_start_byte),
        .s_end_byte    (s_end_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_byte  (m_pixel_byte),
        .m_wipe_done   (m_wipe_done)
    );

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d beats still due", $time, melt_results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // result side ready: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        melt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (melt_results_due.size() == 0) begin
                $display("%0t: beat with nothing due, expected none, got pixel_byte=%02h wipe_done=%0b",
                         $time, m_pixel_byte, m_wipe_done);
                mismatch_count++;
            end else begin
                want = melt_results_due.pop_front();
                if (m_pixel_byte !== want.pixel_byte) begin
                    $display("%0t: pixel_byte expected %02h, got %02h",
                             $time, want.pixel_byte, m_pixel_byte);
                    mismatch_count++;
                end
                if (m_wipe_done !== want.wipe_done) begin
                    $display("%0t: wipe_done expected %0b, got %0b",
                             $time, want.wipe_done, m_wipe_done);
                    mismatch_count++;
                end
            end
        end
    end

    // apply one item to the predicted screen state and return its result
    function automatic melt_result_t melt_predict(input melt_item_t it);
        melt_result_t res;
        int   v;
        int   y;
        int   col;
        int   t;
        int   i;
        int   b;
        logic moved;
        logic take_end;
        res.pixel_byte = 8'h00;
        res.wipe_done = 1'b0;
        case (it.mode)
            MODE_SEED: begin
                // off-screen columns leave everything alone
                if (int'(it.pixel_column) < SCREEN_COLS) begin
                    if (it.pixel_column == 9'd0) begin
                        v = -int'(it.rand_value[3:0]);
                    end else begin
                        // any other column walks from the last seed, in any order
                        v = int'(last_seed) + int'(it.rand_value % 8'd3) - 1;
                        if (v > 0) begin
                            v = 0;
                        end else if (v == -16) begin
                            v = -15;
                        end
                    end
                    col_offset[it.pixel_column] = offset_t'(v);
                    last_seed = seed_sgn_t'(v);
                end
            end
            MODE_TICK: begin
                moved = 1'b0;
                for (t = 0; t < int'(it.tick_count); t++) begin
                    for (i = 0; i < SCREEN_COLS; i++) begin
                        y = int'(col_offset[i]);
                        if (y < 0) begin
                            y = y + 1;
                            moved = 1'b1;
                        end else if (y < SCREEN_ROWS) begin
                            // doubles while short, then falls 8 rows per tick
                            y = y + ((y < 16) ? y + 1 : 8);
                            if (y >= SCREEN_ROWS) begin
                                y = SCREEN_ROWS;
                            end
                            moved = 1'b1;
                        end
                        col_offset[i] = offset_t'(y);
                    end
                end
                res.wipe_done = !moved;
                if (it.tick_count != 4'd0) begin
                    melt_settled = !moved;
                end
            end
            MODE_COMP: begin
                // msb is the leftmost pixel; end image shows above the melt line
                for (b = 0; b < 8; b++) begin
                    col = int'(it.byte_column) * 8 + b;
                    take_end = 1'b0;
                    if (col < SCREEN_COLS) begin
                        y = int'(col_offset[col]);
                        if (y > 0 && int'(it.row) < y) begin
                            take_end = 1'b1;
                        end
                    end
                    res.pixel_byte[7-b] = take_end ? it.end_byte[7-b] : it.start_byte[7-b];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // every field random over its full width
    function automatic melt_item_t any_item();
        melt_item_t it;
        it.mode = 2'($urandom_range(3));
        it.pixel_column = 9'($urandom_range(511));
        it.rand_value = 8'($urandom_range(255));
        it.tick_count = 4'($urandom_range(15));
        it.byte_column = 6'($urandom_range(63));
        it.row = 8'($urandom_range(255));
        it.start_byte = 8'($urandom_range(255));
        it.end_byte = 8'($urandom_range(255));
        return it;
    endfunction

    // offer one beat after a random gap; record its result once accepted
    task automatic offer_beat(input melt_item_t it, input logic typed,
                              input melt_result_t typed_res);
        melt_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode = it.mode;
        s_pixel_column = it.pixel_column;
        s_rand_value = it.rand_value;
        s_tick_count = it.tick_count;
        s_byte_column = it.byte_column;
        s_row = it.row;
        s_start_byte = it.start_byte;
        s_end_byte = it.end_byte;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        res = melt_predict(it);
        melt_results_due.push_back(typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // hold the input side until every due beat has come back
    task automatic drain_results();
        s_valid = 1'b0;
        while (melt_results_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // stimulus
    initial begin
        melt_item_t   it;
        melt_result_t dummy;
        int           k;
        int           wipe;
        int           n;
        int           pick;
        dummy = '0;
        dir_rows = '{
            // unused mode with every bit high
            '{'{MODE_NONE, 9'd511, 8'hFF, 4'hF, 6'd63, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
            // zero ticks: nothing moves
            '{'{MODE_TICK, 9'd0, 8'h00, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1}},
            // byte columns past the right edge keep the start image
            '{'{MODE_COMP, 9'd0, 8'h00, 4'd0, 6'd40, 8'd0, 8'hA5, 8'h5A}, 1'b1, '{8'hA5, 1'b0}},
            '{'{MODE_COMP, 9'd0, 8'h00, 4'd0, 6'd63, 8'd255, 8'h3C, 8'hC3}, 1'b1, '{8'h3C, 1'b0}},
            // off-screen seeds are dropped
            '{'{MODE_SEED, 9'd320, 8'hFF, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd511, 8'h00, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            // seed ahead of column 0 builds on the reset seed
            '{'{MODE_SEED, 9'd5, 8'h07, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            // column 0 at zero, then a step up capped at zero
            '{'{MODE_SEED, 9'd0, 8'h00, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd1, 8'h02, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            // deepest column 0, then a step down clamped at -15
            '{'{MODE_SEED, 9'd0, 8'hFF, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd1, 8'h00, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd2, 8'h02, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd3, 8'h01, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd4, 8'h80, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd5, 8'h0F, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd6, 8'hFE, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            '{'{MODE_SEED, 9'd7, 8'h10, 4'd0, 6'd0, 8'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
            // first byte column, row 0 and row 255
            '{'{MODE_COMP, 9'd0, 8'h00, 4'd0, 6'd0, 8'd0, 8'h96, 8'h69}, 1'b0, '{8'h00, 1'b0}},
            '{'{MODE_COMP, 9'd0, 8'h00, 4'd0, 6'd0, 8'd255, 8'h00, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
            // zero ticks with every other field high
            '{'{MODE_TICK, 9'd511, 8'hFF, 4'd0, 6'd63, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 1'b1}}
        };

        // reset
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows
        for (k = 0; k < DIR_N; k++) begin
            offer_beat(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        // full wipes, each under its own idling pattern
        for (wipe = 0; wipe < WIPE_COUNT; wipe++) begin
            drain_results();
            case (wipe)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase

            // seed every column in order
            for (k = 0; k < SCREEN_COLS; k++) begin
                it = any_item();
                it.mode = MODE_SEED;
                it.pixel_column = 9'(k);
                offer_beat(it, 1'b0, dummy);
            end

            // melt: composes and short ticks, with some noise, until settled or MELT_ITEMS_MAX items
            melt_settled = 1'b0;
            n = 0;
            while (!melt_settled && n < MELT_ITEMS_MAX) begin
                if (wipe == 0 && n == 40) begin
                    hold_request = 600;
                end
                it = any_item();
                pick = $urandom_range(99);
                if (pick < 20) begin
                    it.mode = MODE_TICK;
                    it.tick_count = 4'($urandom_range(3, 1));
                end else if (pick < 90) begin
                    it.mode = MODE_COMP;
                    it.byte_column = 6'($urandom_range(39));
                    it.row = 8'($urandom_range(SCREEN_ROWS - 1));
                end
                offer_beat(it, 1'b0, dummy);
                n++;
            end

            // settled screen: one more tick, then composes at random byte columns and rows
            it = any_item();
            it.mode = MODE_TICK;
            it.tick_count = 4'($urandom_range(3, 1));
            offer_beat(it, 1'b0, dummy);
            repeat (8) begin
                it = any_item();
                it.mode = MODE_COMP;
                offer_beat(it, 1'b0, dummy);
            end
        end

        // wait out the last beats
        s_valid = 1'b0;
        while (melt_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
